@@ rtl/core/arx_sc_pkg.sv @@
// Package for the add-rotate-xor stream cipher: item kinds, sequencer states,
// round constants and the keystream fold order.
// No dependencies.
`default_nettype none

package arx_sc_pkg;

  localparam int WORD_W    = 64;
  localparam int NUM_WORDS = 8;
  localparam int ROT_AMT   = 9;
  localparam int PRE_ROUNDS  = 2;
  localparam int MAIN_ROUNDS = 62;

  localparam int MODE_W  = 2;
  localparam int INDEX_W = 3;
  localparam int BYTE_W  = 8;
  localparam int KW_W    = 4;
  localparam int RCNT_W  = 7;

  // tdata field offsets, lowest bit first
  localparam int IDX_LSB   = 0;
  localparam int KEY_LSB   = IDX_LSB + INDEX_W;
  localparam int NONCE0_LSB = KEY_LSB + WORD_W;
  localparam int NONCE1_LSB = NONCE0_LSB + WORD_W;
  localparam int DATA_LSB  = NONCE1_LSB + WORD_W;
  localparam int TDATA_BITS = DATA_LSB + BYTE_W;
  localparam int TDATA_W   = ((TDATA_BITS + 7) / 8) * 8;

  localparam logic [KW_W-1:0] KEY_WORDS_RESET = 4'd4;
  localparam logic [KW_W-1:0] KEY_WORDS_MAX   = 4'd8;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_KEY   = 2'd0,
    MODE_START = 2'd1,
    MODE_DATA  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SUM    = 5'b00010,
    S_ROUND  = 5'b00100,
    S_STREAM = 5'b01000,
    S_EMIT   = 5'b10000
  } state_t;

  // word folded in at each keystream step: w0, +w6, ^w1, +w5, ^w2, +w4, ^w3, +w7
  function automatic logic [INDEX_W-1:0] ks_word_idx(input logic [INDEX_W-1:0] s);
    logic [INDEX_W-1:0] r;
    case (s)
      3'd0: r = 3'd0;
      3'd1: r = 3'd6;
      3'd2: r = 3'd1;
      3'd3: r = 3'd5;
      3'd4: r = 3'd2;
      3'd5: r = 3'd4;
      3'd6: r = 3'd3;
      default: r = 3'd7;
    endcase
    return r;
  endfunction

  function automatic word_t rotl(input word_t v);
    return (v << ROT_AMT) | (v >> (WORD_W - ROT_AMT));
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/add_rotate_xor_stream_cipher_top.sv @@
// A key item is stored directly from idle. A data item goes to the output register
// through the emit state; when a new keystream block is due it first runs one round
// and the keystream fold. A start item runs two offset sums and 64 rounds.
// One item at a time; the sequencer and its word-serial 64-bit add/rotate path set the rate.
// Synchronous active-high reset clears key store, cipher words and offset; ready at once.
// Depends on arx_sc_pkg.
`default_nettype none

module add_rotate_xor_stream_cipher_top (
  input  wire  logic                            clk,
  input  wire  logic                            rst,
  input  wire  logic                            cfg_valid,
  output logic                                  cfg_ready,
  input  wire  logic [arx_sc_pkg::KW_W-1:0]     cfg_data,   // key_words
  input  wire  logic                            s_axis_tvalid,
  output logic                                  s_axis_tready,
  // word_index, key_value, nonce_first, nonce_second, data_byte, zero pad
  input  wire  logic [arx_sc_pkg::TDATA_W-1:0]  s_axis_tdata,
  input  wire  logic [arx_sc_pkg::MODE_W-1:0]   s_axis_tuser, // mode
  output logic                                  m_axis_tvalid,
  input  wire  logic                            m_axis_tready,
  output logic [arx_sc_pkg::BYTE_W-1:0]         m_axis_tdata  // out_byte
);
  import arx_sc_pkg::*;

  state_t                state;
  word_t                 key_store [NUM_WORDS];
  word_t                 ring [NUM_WORDS];
  word_t                 round_offset;
  word_t                 t;
  word_t                 sum_reg;
  word_t                 w0_raw;
  word_t                 acc;
  word_t                 stream_block;
  logic [INDEX_W-1:0]    byte_pos;
  logic [KW_W-1:0]       key_words;
  logic [3:0]            step;
  logic [RCNT_W-1:0]     rounds;
  logic                  starting;
  logic                  second;
  logic [BYTE_W-1:0]     data_hold;

  mode_t                 in_mode;
  logic [INDEX_W-1:0]    in_idx;
  word_t                 in_key;
  word_t                 in_n0;
  word_t                 in_n1;
  logic [BYTE_W-1:0]     in_data;
  logic [KW_W-1:0]       load_count;
  word_t                 load_words [NUM_WORDS];
  word_t                 nxt;
  word_t                 t_src;
  word_t                 raw;
  word_t                 ks_word;
  logic [BYTE_W-1:0]     ks_byte;

  assign in_mode = mode_t'(s_axis_tuser);
  assign in_idx  = s_axis_tdata[IDX_LSB +: INDEX_W];
  assign in_key  = s_axis_tdata[KEY_LSB +: WORD_W];
  assign in_n0   = s_axis_tdata[NONCE0_LSB +: WORD_W];
  assign in_n1   = s_axis_tdata[NONCE1_LSB +: WORD_W];
  assign in_data = s_axis_tdata[DATA_LSB +: BYTE_W];

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE);

  assign load_count = (key_words > KEY_WORDS_MAX) ? KEY_WORDS_MAX : key_words;

  always_comb begin
    for (int i = 0; i < NUM_WORDS; i++) begin
      load_words[i] = (KW_W'(i) < load_count) ? key_store[i] : ring[i];
    end
    load_words[0] = load_words[0] ^ in_n0;
    load_words[1] = load_words[1] ^ in_n1;
  end

  // word 7 pairs with the already updated (pre-xor) word 0
  assign nxt     = (step[3:1] == 3'd7) ? w0_raw : ring[1];
  assign t_src   = (step[3:1] == 3'd0) ? round_offset : t;
  assign raw     = rotl(sum_reg ^ ring[0]);
  assign ks_word = ring[ks_word_idx(step[2:0])];
  assign ks_byte = stream_block[{byte_pos, 3'b000} +: BYTE_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      key_store    <= '{default: '0};
      ring         <= '{default: '0};
      round_offset <= '0;
      stream_block <= '0;
      byte_pos     <= '0;
      key_words    <= KEY_WORDS_RESET;
      step         <= '0;
      rounds       <= '0;
      starting     <= 1'b0;
      second       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        key_words <= cfg_data;
      end
      if (m_axis_tvalid && m_axis_tready && (state != S_EMIT)) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            case (in_mode)
              MODE_KEY: begin
                key_store[in_idx] <= in_key;
              end
              MODE_START: begin
                ring         <= load_words;
                round_offset <= '0;
                byte_pos     <= '0;
                starting     <= 1'b1;
                second       <= 1'b0;
                step         <= '0;
                state        <= S_SUM;
              end
              MODE_DATA: begin
                data_hold <= in_data;
                if (byte_pos == '0) begin
                  rounds   <= RCNT_W'(1);
                  starting <= 1'b0;
                  step     <= '0;
                  state    <= S_ROUND;
                end else begin
                  state <= S_EMIT;
                end
              end
              default: begin
              end
            endcase
          end
        end

        S_SUM: begin
          round_offset <= round_offset + ring[0];
          for (int i = 0; i < NUM_WORDS - 1; i++) begin
            ring[i] <= ring[i+1];
          end
          ring[NUM_WORDS-1] <= ring[0];
          if (step[2:0] == 3'd7) begin
            step   <= '0;
            rounds <= second ? RCNT_W'(MAIN_ROUNDS) : RCNT_W'(PRE_ROUNDS);
            state  <= S_ROUND;
          end else begin
            step <= step + 4'd1;
          end
        end

        S_ROUND: begin
          if (!step[0]) begin
            sum_reg <= ring[0] + nxt + t_src;
            t       <= t_src;
            step    <= step + 4'd1;
          end else begin
            for (int i = 0; i < NUM_WORDS - 1; i++) begin
              ring[i] <= ring[i+1];
            end
            ring[NUM_WORDS-1] <= raw ^ ring[0];
            t <= t + raw;
            if (step[3:1] == 3'd0) begin
              w0_raw <= raw;
            end
            if (step == 4'd15) begin
              step   <= '0;
              rounds <= rounds - RCNT_W'(1);
              if (rounds == RCNT_W'(1)) begin
                if (!starting) begin
                  state <= S_STREAM;
                end else if (!second) begin
                  second <= 1'b1;
                  state  <= S_SUM;
                end else begin
                  state <= S_IDLE;
                end
              end
            end else begin
              step <= step + 4'd1;
            end
          end
        end

        S_STREAM: begin
          if (step[2:0] == 3'd0) begin
            acc <= ks_word;
          end else if (step[0]) begin
            acc <= acc + ks_word;
          end else begin
            acc <= acc ^ ks_word;
          end
          if (step[2:0] == 3'd7) begin
            stream_block <= acc + ks_word;
            step         <= '0;
            state        <= S_EMIT;
          end else begin
            step <= step + 4'd1;
          end
        end

        S_EMIT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata  <= data_hold ^ ks_byte;
            m_axis_tvalid <= 1'b1;
            byte_pos      <= byte_pos + INDEX_W'(1);
            state         <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_round_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND) |-> (rounds != '0))
    else $error("round sequencer ran with no rounds left");

  a_block_at_zero: assert property (@(posedge clk) disable iff (rst)
    (state == S_STREAM) |-> (byte_pos == '0))
    else $error("keystream block built mid block");

  a_start_clears_pos: assert property (@(posedge clk) disable iff (rst)
    (state == S_SUM) |-> (byte_pos == '0) && starting)
    else $error("offset sum outside start sequence");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) && (!m_axis_tvalid || m_axis_tready)
      |=> m_axis_tvalid && (state == S_IDLE))
    else $error("result item not loaded");
`endif

endmodule

`default_nettype wire

@@ verif/arx_keystream_checker.sv @@
// Checker for the add-rotate-xor stream cipher: watches the config, input and output
// channels, predicts every output byte and compares it in order.
// Depends on arx_sc_pkg.
`timescale 1ns / 1ps

module arx_keystream_checker
  import arx_sc_pkg::*;
(
  input  wire  logic                clk,
  input  wire  logic                rst,
  input  wire  logic                cfg_valid,
  input  wire  logic                cfg_ready,
  input  wire  logic [KW_W-1:0]     cfg_data,
  input  wire  logic                s_axis_tvalid,
  input  wire  logic                s_axis_tready,
  input  wire  logic [TDATA_W-1:0]  s_axis_tdata,
  input  wire  logic [MODE_W-1:0]   s_axis_tuser,
  input  wire  logic                m_axis_tvalid,
  input  wire  logic                m_axis_tready,
  input  wire  logic [BYTE_W-1:0]   m_axis_tdata,
  output int                        mismatches,
  output int                        expected_left
);

  word_t              key_mem [NUM_WORDS];
  word_t              state_words [NUM_WORDS];
  word_t              round_off;
  word_t              ks_block;
  logic [2:0]         ks_pos;
  logic [KW_W-1:0]    key_count;
  logic [BYTE_W-1:0]  expected_bytes [$];
  int                 fail_total = 0;

  initial begin
    mismatches    = 0;
    expected_left = 0;
  end

  function automatic word_t rot9(input word_t v);
    return {v[WORD_W-10:0], v[WORD_W-1:WORD_W-9]};
  endfunction

  function automatic void mix_round();
    word_t prior [NUM_WORDS];
    word_t acc;
    word_t sum;
    prior = state_words;
    acc   = round_off;
    for (int i = 0; i < NUM_WORDS; i++) begin
      sum            = state_words[i] + state_words[(i + 1) % NUM_WORDS] + acc;
      state_words[i] = rot9(sum ^ state_words[i]);
      acc            = acc + state_words[i];
    end
    for (int i = 0; i < NUM_WORDS; i++)
      state_words[i] = state_words[i] ^ prior[i];
  endfunction

  function automatic void absorb_words();
    for (int i = 0; i < NUM_WORDS; i++)
      round_off = round_off + state_words[i];
  endfunction

  function automatic void restart_stream(input word_t n0, input word_t n1);
    int n;
    n = (key_count > KEY_WORDS_MAX) ? KEY_WORDS_MAX : key_count;
    for (int i = 0; i < n; i++)
      state_words[i] = key_mem[i];
    state_words[0] = state_words[0] ^ n0;
    state_words[1] = state_words[1] ^ n1;
    round_off = '0;
    absorb_words();
    repeat (PRE_ROUNDS) mix_round();
    absorb_words();
    repeat (MAIN_ROUNDS) mix_round();
    ks_pos = '0;
  endfunction

  function automatic void predict_item(input mode_t m, input logic [TDATA_W-1:0] beat);
    logic [BYTE_W-1:0] b;
    b = beat[DATA_LSB +: BYTE_W];
    case (m)
      MODE_KEY: begin
        key_mem[beat[IDX_LSB +: INDEX_W]] = beat[KEY_LSB +: WORD_W];
      end
      MODE_START: begin
        restart_stream(beat[NONCE0_LSB +: WORD_W], beat[NONCE1_LSB +: WORD_W]);
      end
      MODE_DATA: begin
        if (ks_pos == 3'd0) begin
          mix_round();
          ks_block = ((((((state_words[0] + state_words[6]) ^ state_words[1])
                     + state_words[5]) ^ state_words[2]) + state_words[4])
                     ^ state_words[3]) + state_words[7];
        end
        expected_bytes.push_back(b ^ ks_block[{ks_pos, 3'b000} +: BYTE_W]);
        ks_pos = ks_pos + 3'd1;
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin : watch
    logic [BYTE_W-1:0] want;
    if (rst) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        key_mem[i]     = '0;
        state_words[i] = '0;
      end
      round_off = '0;
      ks_block  = '0;
      ks_pos    = '0;
      key_count = KEY_WORDS_RESET;
      expected_bytes.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_bytes.size() == 0) begin
          fail_total++;
          $display("%0t: out_byte expected none, actual %02h", $time, m_axis_tdata);
        end else begin
          want = expected_bytes.pop_front();
          if (m_axis_tdata !== want) begin
            fail_total++;
            $display("%0t: out_byte expected %02h, actual %02h", $time, want, m_axis_tdata);
          end
        end
      end
      if (cfg_valid && cfg_ready)
        key_count = cfg_data;
      if (s_axis_tvalid && s_axis_tready)
        predict_item(mode_t'(s_axis_tuser), s_axis_tdata);
    end
    mismatches    <= fail_total;
    expected_left <= expected_bytes.size();
  end

endmodule

@@ verif/tb.sv @@
// Testbench top for add_rotate_xor_stream_cipher_top: clock, reset, key/start/data
// stimulus with random stalls on both sides, and the final verdict.
// Depends on arx_sc_pkg, the block and arx_keystream_checker.
`timescale 1ns / 1ps

module tb;
  import arx_sc_pkg::*;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int SETTLE_CYCLES  = 1100;  // covers a start item still in flight
  localparam int HOLD_CYCLES    = 300;
  localparam int ITEM_TARGET    = 1900;
  localparam int PHASES         = 8;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [KW_W-1:0]      cfg_data = KEY_WORDS_RESET;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [TDATA_W-1:0]   s_axis_tdata = '0;
  logic [MODE_W-1:0]    s_axis_tuser = MODE_KEY;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [BYTE_W-1:0]    m_axis_tdata;

  int mismatches;
  int expected_left;
  int items_sent = 0;
  int idle_cycles = 0;
  bit tx_gaps = 1'b0;
  bit rx_gaps = 1'b0;
  bit quiet_tail = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  add_rotate_xor_stream_cipher_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  arx_keystream_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .mismatches    (mismatches),
    .expected_left (expected_left)
  );

  function automatic word_t rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic word_t pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return rand_word();
    endcase
  endfunction

  function automatic logic [KW_W-1:0] phase_key_words(input int p);
    case (p)
      0:       return 4'd0;
      1:       return KEY_WORDS_MAX;
      2:       return 4'd15;
      3:       return 4'd1;
      4:       return 4'd9;
      5:       return KW_W'($urandom_range(0, 15));
      6:       return KW_W'($urandom_range(1, 8));
      default: return KEY_WORDS_MAX;
    endcase
  endfunction

  task automatic push_item(input mode_t m, input logic [INDEX_W-1:0] idx, input word_t key,
                           input word_t n0, input word_t n1, input logic [BYTE_W-1:0] b);
    logic [TDATA_W-1:0] beat;
    beat = '0;
    beat[IDX_LSB +: INDEX_W]   = idx;
    beat[KEY_LSB +: WORD_W]    = key;
    beat[NONCE0_LSB +: WORD_W] = n0;
    beat[NONCE1_LSB +: WORD_W] = n1;
    beat[DATA_LSB +: BYTE_W]   = b;
    if (tx_gaps && !quiet_tail && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= beat;
    s_axis_tuser  <= m;
    do @(posedge clk); while (!s_axis_tready);
    if (m != MODE_NONE)
      items_sent++;
  endtask

  task automatic send_key(input int idx, input word_t v);
    push_item(MODE_KEY, INDEX_W'(idx), v, rand_word(), rand_word(), BYTE_W'($urandom));
  endtask

  task automatic send_start(input word_t n0, input word_t n1);
    push_item(MODE_START, INDEX_W'($urandom), rand_word(), n0, n1, BYTE_W'($urandom));
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    push_item(MODE_DATA, INDEX_W'($urandom), rand_word(), rand_word(), rand_word(), b);
  endtask

  task automatic send_noise();
    push_item(MODE_NONE, INDEX_W'($urandom), rand_word(), rand_word(), rand_word(),
              BYTE_W'($urandom));
  endtask

  // wait for the last expected byte, then for any start item still running
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (expected_left != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_key_words(input logic [KW_W-1:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_session();
    int len;
    tx_gaps = ($urandom_range(0, 2) != 0);
    rx_gaps = ($urandom_range(0, 2) != 0);
    if ($urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 4)) send_key($urandom_range(0, 7), pick_word());
    if ($urandom_range(0, 15) == 0)
      send_noise();
    if ($urandom_range(0, 9) != 0)
      send_start(pick_word(), pick_word());
    len = ($urandom_range(0, 15) == 0) ? $urandom_range(25, 64) : $urandom_range(0, 24);
    repeat (len) send_byte(BYTE_W'($urandom_range(0, 255)));
  endtask

  // receiver: random stall bursts plus a long hold-off every few hundred bytes
  initial begin
    int taken;
    int next_hold;
    int gap;
    taken     = 0;
    next_hold = 120;
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready)
        taken++;
      if (!quiet_tail && taken >= next_hold) begin
        next_hold += 700;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (rx_gaps && !quiet_tail && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        gap = $urandom_range(1, 17);
        repeat (gap - 1) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** add_rotate_xor_stream_cipher_top: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // data before any start runs on the all-zero state
    send_byte(8'h00);
    send_byte(8'hFF);
    send_key(0, '1);
    send_key(1, '0);
    for (int i = 2; i < NUM_WORDS; i++)
      send_key(i, rand_word());
    send_noise();
    send_start('1, '0);
    for (int i = 0; i < 9; i++)
      send_byte(i[0] ? 8'hFF : 8'h00);
    // restart in the middle of a block
    send_start('0, '1);
    send_byte(8'hA5);
    send_byte(BYTE_W'($urandom_range(0, 255)));

    for (int p = 0; p < PHASES; p++) begin
      quiet_tail = (p == PHASES - 1);
      write_key_words(phase_key_words(p));
      while (items_sent < ITEM_TARGET * (p + 1) / PHASES)
        run_session();
    end

    settle();
    if (mismatches == 0 && expected_left == 0) begin
      $display("** add_rotate_xor_stream_cipher_top: PASSED **");
    end else begin
      $display("** add_rotate_xor_stream_cipher_top: FAILED **");
    end
    $finish;
  end

endmodule
